// File: sv/gnts_pkg.sv
`default_nettype none
package gnts_pkg;

  localparam int POS_W       = 8;
  localparam int TYPE_IN_W   = 4;
  localparam int RANGE_W     = 10;
  localparam int CODE_W      = 4;
  localparam int OUT_COORD_W = 11;
  // signed probe coordinates: center 0..255 plus or minus a ring distance below 1023
  localparam int COORD_W     = 12;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic [CODE_W-1:0] INVALID_CODE_RST = 4'd15;

  typedef struct packed {
    logic clr_en;    // write zero at the clearing address
    logic wr_en;     // store the input item's type code
    logic start;     // capture a search item and seed the ring walk
    logic issue;     // read the current probe and step the walk
    logic adv;       // move the read stage forward
    logic load_res;  // put the outcome into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic gen_valid;
    logic p1_valid;
    logic hit;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: sv/gnts_ctrl.sv
`default_nettype none
module gnts_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_kind,
  output logic                in_stall,
  input  gnts_pkg::dp_status_t st,
  output gnts_pkg::dp_cmd_t    cmd
);
  import gnts_pkg::*;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (st.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.adv  = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (st.p1_valid && st.hit) begin
          // hold everything while the previous result still waits
          if (st.out_free) begin
            cmd.load_res = 1'b1;
            cmd.adv      = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else if (st.gen_valid) begin
          cmd.issue = 1'b1;
          cmd.adv   = 1'b1;
        end else if (st.p1_valid) begin
          cmd.adv = 1'b1;
        end else if (st.out_free) begin
          cmd.load_res = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/gnts_datapath.sv
`default_nettype none
module gnts_datapath #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256,
  parameter int TYPE_BITS   = 4
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire  [gnts_pkg::POS_W-1:0]             in_pos_x,
  input  wire  [gnts_pkg::POS_W-1:0]             in_pos_y,
  input  wire  [gnts_pkg::TYPE_IN_W-1:0]         in_block_type,
  input  wire  [gnts_pkg::RANGE_W-1:0]           in_search_range,
  input  wire                                    in_skip_center,
  input  wire                                    cfg_wr_en,
  input  wire  [gnts_pkg::CODE_W-1:0]            cfg_wr_data,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic                                   out_found,
  output logic signed [gnts_pkg::OUT_COORD_W-1:0] out_found_x,
  output logic signed [gnts_pkg::OUT_COORD_W-1:0] out_found_y,
  input  gnts_pkg::dp_cmd_t                      cmd,
  output gnts_pkg::dp_status_t                   st
);
  import gnts_pkg::*;

  localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW     = $clog2(GRID_WIDTH);
  localparam int YW     = $clog2(GRID_HEIGHT);
  localparam int CMP_W  = (TYPE_BITS > CODE_W) ? TYPE_BITS : CODE_W;

  localparam logic [1:0] SEG_CENTER = 2'd0;
  localparam logic [1:0] SEG_A      = 2'd1;
  localparam logic [1:0] SEG_B      = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  function automatic logic in_grid(input coord_t x, input coord_t y);
    in_grid = !x[COORD_W-1] && !y[COORD_W-1] &&
              (int'(x) < GRID_WIDTH) && (int'(y) < GRID_HEIGHT);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input coord_t x, input coord_t y);
    cell_addr = ADDR_W'(y[YW-1:0] * GRID_WIDTH) + ADDR_W'(x[XW-1:0]);
  endfunction

  // cell store, one write and one read port
  logic [TYPE_BITS-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]    clr_addr_r;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_wa;
  logic [TYPE_BITS-1:0] mem_wd;
  coord_t               wr_x;
  coord_t               wr_y;

  logic [CODE_W-1:0]    invalid_code_r;

  // search item and ring walk
  logic [POS_W-1:0]     cx_r;
  logic [POS_W-1:0]     cy_r;
  logic [TYPE_IN_W-1:0] type_r;
  logic [RANGE_W-1:0]   range_r;
  logic                 gen_valid_r, gen_valid_nxt;
  logic [1:0]           seg_r, seg_nxt;
  logic [RANGE_W-1:0]   d_r, d_nxt;
  logic [RANGE_W-1:0]   i_r, i_nxt;
  logic                 side_r, side_nxt;
  coord_t               cxs, cys, dd, ii, px, py;
  logic [RANGE_W:0]     d_inc;

  // read stage
  logic                 p1_valid_r;
  coord_t               p1_x_r;
  coord_t               p1_y_r;
  logic                 p1_in_r;
  logic [TYPE_BITS-1:0] rd_data_r;
  logic [CMP_W-1:0]     cell_code;

  logic                 res_found;

  assign wr_x   = COORD_W'(in_pos_x);
  assign wr_y   = COORD_W'(in_pos_y);
  assign mem_we = cmd.clr_en || (cmd.wr_en && in_grid(wr_x, wr_y));
  assign mem_wa = cmd.clr_en ? clr_addr_r : cell_addr(wr_x, wr_y);
  assign mem_wd = cmd.clr_en ? '0 : TYPE_BITS'(in_block_type);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= mem[cell_addr(px, py)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign st.clr_last = (clr_addr_r == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invalid_code_r <= INVALID_CODE_RST;
    end else if (cfg_wr_en) begin
      invalid_code_r <= cfg_wr_data;
    end
  end

  // probe position for the current walk step
  always_comb begin
    cxs = $signed(COORD_W'(cx_r));
    cys = $signed(COORD_W'(cy_r));
    dd  = $signed(COORD_W'(d_r));
    ii  = $signed(COORD_W'(i_r));
    px  = cxs;
    py  = cys;
    case (seg_r)
      SEG_A: begin
        if (!side_r) begin
          px = cxs - dd + ii;
          py = cys - ii;
        end else begin
          px = cxs + dd - ii;
          py = cys + ii;
        end
      end
      SEG_B: begin
        if (!side_r) begin
          px = cxs - ii;
          py = cys + dd - ii;
        end else begin
          px = cxs + ii;
          py = cys - dd + ii;
        end
      end
      default: begin
        px = cxs;
        py = cys;
      end
    endcase
  end

  assign d_inc = {1'b0, d_r} + 1'b1;

  always_comb begin
    gen_valid_nxt = gen_valid_r;
    seg_nxt       = seg_r;
    d_nxt         = d_r;
    i_nxt         = i_r;
    side_nxt      = side_r;
    if (cmd.start) begin
      seg_nxt       = in_skip_center ? SEG_A : SEG_CENTER;
      gen_valid_nxt = !in_skip_center || (in_search_range > RANGE_W'(1));
      d_nxt         = RANGE_W'(1);
      i_nxt         = '0;
      side_nxt      = 1'b0;
    end else if (cmd.issue) begin
      if (seg_r == SEG_CENTER) begin
        seg_nxt       = SEG_A;
        gen_valid_nxt = (range_r > RANGE_W'(1));
        d_nxt         = RANGE_W'(1);
        i_nxt         = '0;
        side_nxt      = 1'b0;
      end else if (!side_r) begin
        side_nxt = 1'b1;
      end else begin
        side_nxt = 1'b0;
        if ((seg_r == SEG_A && i_r != d_r) ||
            (seg_r == SEG_B && (i_r + 1'b1) < d_r)) begin
          i_nxt = i_r + 1'b1;
        end else if (seg_r == SEG_A && d_r > RANGE_W'(1)) begin
          seg_nxt = SEG_B;
          i_nxt   = RANGE_W'(1);
        end else begin
          // ring done, move out one distance
          seg_nxt       = SEG_A;
          i_nxt         = '0;
          d_nxt         = d_inc[RANGE_W-1:0];
          gen_valid_nxt = (d_inc < {1'b0, range_r});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_valid_r <= 1'b0;
    end else begin
      gen_valid_r <= gen_valid_nxt;
    end
    seg_r  <= seg_nxt;
    d_r    <= d_nxt;
    i_r    <= i_nxt;
    side_r <= side_nxt;
    if (cmd.start) begin
      cx_r    <= in_pos_x;
      cy_r    <= in_pos_y;
      type_r  <= in_block_type;
      range_r <= in_search_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (cmd.start) begin
      p1_valid_r <= 1'b0;
    end else if (cmd.adv) begin
      p1_valid_r <= cmd.issue;
    end
    if (cmd.issue) begin
      p1_x_r  <= px;
      p1_y_r  <= py;
      p1_in_r <= in_grid(px, py);
    end
  end

  assign cell_code   = p1_in_r ? CMP_W'(rd_data_r) : CMP_W'(invalid_code_r);
  assign st.hit      = (cell_code == CMP_W'(type_r));
  assign st.p1_valid = p1_valid_r;
  assign st.gen_valid = gen_valid_r;
  assign st.out_free = !out_valid || !out_stall;

  assign res_found = p1_valid_r && st.hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.load_res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_res) begin
      out_found   <= res_found;
      out_found_x <= res_found ? p1_x_r[OUT_COORD_W-1:0] : '1;
      out_found_y <= res_found ? p1_y_r[OUT_COORD_W-1:0] : '1;
    end
  end

endmodule
`default_nettype wire

// File: sv/grid_nearest_type_search.sv
// Nearest cell of a given type on a grid of type codes.
// Input channel (in_valid / in_stall): in_kind selects a cell write or a
// search. A write stores in_block_type at (in_pos_x, in_pos_y) and gives no
// result. A search tests the center (unless in_skip_center), then walks
// Manhattan rings 1 .. in_search_range-1 and returns the first match.
// Cells outside the grid read as the code in the cfg_wr_en / cfg_wr_data
// register (15 after reset).
// Output channel (out_valid / out_stall): out_found, out_found_x, out_found_y;
// -1, -1 when nothing matched.
// Probing: the cell store has one read port and each probe is one read, so a
// search reads its cells one after another. One item is in work at a time.
// After reset the store is cleared one cell a cycle, all GRID_WIDTH * GRID_HEIGHT
// cells (65536 by default), with in_stall high; config writes are still taken.
// A finished result sits in the output register; the next item can be taken while
// it waits; a second search holds at its match or its end until out_stall drops.
`default_nettype none
module grid_nearest_type_search #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256,
  parameter int TYPE_BITS   = 4
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     in_valid,
  output logic                                    in_stall,
  input  wire                                     in_kind,
  input  wire  [gnts_pkg::POS_W-1:0]              in_pos_x,
  input  wire  [gnts_pkg::POS_W-1:0]              in_pos_y,
  input  wire  [gnts_pkg::TYPE_IN_W-1:0]          in_block_type,
  input  wire  [gnts_pkg::RANGE_W-1:0]            in_search_range,
  input  wire                                     in_skip_center,
  output logic                                    out_valid,
  input  wire                                     out_stall,
  output logic                                    out_found,
  output logic signed [gnts_pkg::OUT_COORD_W-1:0] out_found_x,
  output logic signed [gnts_pkg::OUT_COORD_W-1:0] out_found_y,
  input  wire                                     cfg_wr_en,
  input  wire  [gnts_pkg::CODE_W-1:0]             cfg_wr_data
);
  import gnts_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  gnts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  gnts_datapath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .TYPE_BITS   (TYPE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_block_type   (in_block_type),
    .in_search_range (in_search_range),
    .in_skip_center  (in_skip_center),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_found_x     (out_found_x),
    .out_found_y     (out_found_y),
    .cmd             (cmd),
    .st              (st)
  );

endmodule
`default_nettype wire
